[hw/rtl/bsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants for the barometric sensor compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int CONV_W  = 24;   // raw conversion width
    localparam int WORD_W  = 16;   // calibration word width
    localparam int IDX_W   = 3;    // configuration index width
    localparam int DT_W    = 25;   // signed temperature difference
    localparam int TEMP_W  = 19;   // temperature in centidegrees
    localparam int T2_W    = 18;   // second-order temperature term
    localparam int SQ_W    = 37;   // squared temperature distances
    localparam int OFF_W   = 40;   // offset / sensitivity, signed
    localparam int PRESS_W = 32;

    localparam int TEMP_REF  = 2000;
    localparam int TEMP_COLD = -1500;

    typedef enum logic [IDX_W-1:0] {
        REG_SENS     = 3'd0,
        REG_OFF      = 3'd1,
        REG_TCS      = 3'd2,
        REG_TCO      = 3'd3,
        REG_TREF     = 3'd4,
        REG_TEMPSENS = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [WORD_W-1:0] sens;
        logic [WORD_W-1:0] off;
        logic [WORD_W-1:0] tcs;
        logic [WORD_W-1:0] tco;
        logic [WORD_W-1:0] tref;
        logic [WORD_W-1:0] tempsens;
    } coef_t;

    // first-order results
    typedef struct packed {
        logic        [CONV_W-1:0] d1;
        logic signed [TEMP_W-1:0] temp;
        logic        [T2_W-1:0]   t2;
        logic signed [OFF_W-1:0]  off1;
        logic signed [OFF_W-1:0]  sens1;
    } fo_t;

    // corrected offset and sensitivity, final temperature
    typedef struct packed {
        logic        [CONV_W-1:0] d1;
        logic signed [TEMP_W-1:0] temp_out;
        logic                     cold;
        logic signed [OFF_W-1:0]  off;
        logic signed [OFF_W-1:0]  sens;
    } so_t;

endpackage

[hw/rtl/bsc_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_cfg_regs
// Calibration word register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bsc_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bsc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bsc_pkg::WORD_W-1:0]   cfg_wdata,
    output bsc_pkg::coef_t               coef
);

    bsc_pkg::coef_t coef_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (bsc_pkg::cfg_idx_t'(cfg_index))
                bsc_pkg::REG_SENS:     coef_reg.sens     <= cfg_wdata;
                bsc_pkg::REG_OFF:      coef_reg.off      <= cfg_wdata;
                bsc_pkg::REG_TCS:      coef_reg.tcs      <= cfg_wdata;
                bsc_pkg::REG_TCO:      coef_reg.tco      <= cfg_wdata;
                bsc_pkg::REG_TREF:     coef_reg.tref     <= cfg_wdata;
                bsc_pkg::REG_TEMPSENS: coef_reg.tempsens <= cfg_wdata;
                default:               coef_reg          <= coef_reg;
            endcase
        end
    end

    assign coef = coef_reg;

endmodule

[hw/rtl/bsc_first_order.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_first_order
// Three stages: dT, the four products, first-order TEMP / OFF / SENS and T2.
// ----------------------------------------------------------------------------
module bsc_first_order
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  bsc_pkg::coef_t               coef,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [bsc_pkg::CONV_W-1:0]   d2,
    input  logic [bsc_pkg::CONV_W-1:0]   d1,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bsc_pkg::fo_t                 fo
);

    localparam int MP_W = 42;   // dT times a 16-bit word, signed
    localparam int DD_W = 49;   // dT squared, never negative

    logic v1_reg, v2_reg, v3_reg;
    logic hold1, hold2, hold3;

    assign hold3    = v3_reg & out_stall;
    assign hold2    = v2_reg & hold3;
    assign hold1    = v1_reg & hold2;
    assign in_stall = hold1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (!hold1) v1_reg <= in_valid;
            if (!hold2) v2_reg <= v1_reg;
            if (!hold3) v3_reg <= v2_reg;
        end
    end

    // stage 1: dT
    logic        [bsc_pkg::CONV_W-1:0] d1_1_reg;
    logic signed [bsc_pkg::DT_W-1:0]   dt_1_reg;
    logic signed [bsc_pkg::DT_W-1:0]   dt_next;

    assign dt_next = $signed({1'b0, d2}) - $signed({1'b0, coef.tref, 8'h00});

    // stage 2: products
    logic        [bsc_pkg::CONV_W-1:0] d1_2_reg;
    logic signed [MP_W-1:0]            mt_reg, mo_reg, ms_reg;
    logic signed [MP_W-1:0]            mt_next, mo_next, ms_next;
    logic        [DD_W-1:0]            dd_reg;
    logic signed [DD_W:0]              dd_next;

    assign mt_next = dt_1_reg * $signed({1'b0, coef.tempsens});
    assign mo_next = dt_1_reg * $signed({1'b0, coef.tco});
    assign ms_next = dt_1_reg * $signed({1'b0, coef.tcs});
    assign dd_next = dt_1_reg * dt_1_reg;

    // stage 3: truncating shifts and the base terms
    logic signed [MP_W-1:0] mt_adj, mo_adj, ms_adj;
    logic signed [MP_W-1:0] qt, qo, qs;
    bsc_pkg::fo_t           fo_next, fo_reg;

    assign mt_adj = mt_reg + $signed({{(MP_W-23){1'b0}}, {23{mt_reg[MP_W-1]}}});
    assign mo_adj = mo_reg + $signed({{(MP_W-7){1'b0}},  {7{mo_reg[MP_W-1]}}});
    assign ms_adj = ms_reg + $signed({{(MP_W-8){1'b0}},  {8{ms_reg[MP_W-1]}}});
    assign qt     = mt_adj >>> 23;
    assign qo     = mo_adj >>> 7;
    assign qs     = ms_adj >>> 8;

    always_comb
    begin
        fo_next.d1    = d1_2_reg;
        fo_next.temp  = qt[bsc_pkg::TEMP_W-1:0]
                      + bsc_pkg::TEMP_W'(bsc_pkg::TEMP_REF);
        fo_next.t2    = dd_reg[DD_W-1:31];
        fo_next.off1  = bsc_pkg::OFF_W'(qo)
                      + $signed({8'h00, coef.off, 16'h0000});
        fo_next.sens1 = bsc_pkg::OFF_W'(qs)
                      + $signed({9'h000, coef.sens, 15'h0000});
    end

    always_ff @(posedge clk)
    begin
        if (!hold1 && in_valid)
        begin
            d1_1_reg <= d1;
            dt_1_reg <= dt_next;
        end
        if (!hold2 && v1_reg)
        begin
            d1_2_reg <= d1_1_reg;
            mt_reg   <= mt_next;
            mo_reg   <= mo_next;
            ms_reg   <= ms_next;
            dd_reg   <= dd_next[DD_W-1:0];
        end
        if (!hold3 && v2_reg)
        begin
            fo_reg <= fo_next;
        end
    end

    assign out_valid = v3_reg;
    assign fo        = fo_reg;

endmodule

[hw/rtl/bsc_second_order.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_second_order
// Three stages: cold flags and squares, OFF2 / SENS2 / T2 terms, correction.
// ----------------------------------------------------------------------------
module bsc_second_order
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bsc_pkg::fo_t    fo,
    output logic            out_valid,
    input  logic            out_stall,
    output bsc_pkg::so_t    so
);

    localparam int TW  = bsc_pkg::TEMP_W;
    localparam int SQW = bsc_pkg::SQ_W;
    localparam int OW  = bsc_pkg::OFF_W;

    logic v1_reg, v2_reg, v3_reg;
    logic hold1, hold2, hold3;

    assign hold3    = v3_reg & out_stall;
    assign hold2    = v2_reg & hold3;
    assign hold1    = v1_reg & hold2;
    assign in_stall = hold1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (!hold1) v1_reg <= in_valid;
            if (!hold2) v2_reg <= v1_reg;
            if (!hold3) v3_reg <= v2_reg;
        end
    end

    // stage 1: distances from the two thresholds, squared
    logic signed [TW-1:0]  a_dist, b_dist;
    logic signed [2*TW-1:0] aa_full, bb_full;

    assign a_dist  = fo.temp - TW'(bsc_pkg::TEMP_REF);
    assign b_dist  = fo.temp - TW'(bsc_pkg::TEMP_COLD);
    assign aa_full = a_dist * a_dist;
    assign bb_full = b_dist * b_dist;

    bsc_pkg::fo_t   fo1_reg;
    logic           cold1_reg, severe1_reg;
    logic [SQW-1:0] aa_reg, bb_reg;

    // stage 2: correction terms, zero when warm
    logic [OW:0]    aa5, bb7, bb11;
    logic [OW-1:0]  off2_next, sens2_next;
    logic signed [TW-1:0] temp_out_next;

    assign aa5  = (OW+1)'(aa_reg) + ((OW+1)'(aa_reg) << 2);
    assign bb7  = ((OW+1)'(bb_reg) << 3) - (OW+1)'(bb_reg);
    assign bb11 = ((OW+1)'(bb_reg) << 3) + ((OW+1)'(bb_reg) << 1) + (OW+1)'(bb_reg);

    always_comb
    begin
        off2_next     = '0;
        sens2_next    = '0;
        temp_out_next = fo1_reg.temp;
        if (cold1_reg)
        begin
            off2_next     = OW'(aa5 >> 1);
            sens2_next    = OW'(aa5 >> 2);
            temp_out_next = fo1_reg.temp - TW'(fo1_reg.t2);
            if (severe1_reg)
            begin
                off2_next  = off2_next + OW'(bb7);
                sens2_next = sens2_next + OW'(bb11 >> 1);
            end
        end
    end

    logic        [bsc_pkg::CONV_W-1:0] d1_2_reg;
    logic signed [TW-1:0]              temp_out_2_reg;
    logic                              cold2_reg;
    logic signed [OW-1:0]              off1_2_reg, sens1_2_reg;
    logic        [OW-1:0]              off2_reg, sens2_reg;

    // stage 3: subtract
    bsc_pkg::so_t so_next, so_reg;

    always_comb
    begin
        so_next.d1       = d1_2_reg;
        so_next.temp_out = temp_out_2_reg;
        so_next.cold     = cold2_reg;
        so_next.off      = off1_2_reg - $signed(off2_reg);
        so_next.sens     = sens1_2_reg - $signed(sens2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (!hold1 && in_valid)
        begin
            fo1_reg     <= fo;
            cold1_reg   <= fo.temp < TW'(bsc_pkg::TEMP_REF);
            severe1_reg <= fo.temp < TW'(bsc_pkg::TEMP_COLD);
            aa_reg      <= aa_full[SQW-1:0];
            bb_reg      <= bb_full[SQW-1:0];
        end
        if (!hold2 && v1_reg)
        begin
            d1_2_reg       <= fo1_reg.d1;
            temp_out_2_reg <= temp_out_next;
            cold2_reg      <= cold1_reg;
            off1_2_reg     <= fo1_reg.off1;
            sens1_2_reg    <= fo1_reg.sens1;
            off2_reg       <= off2_next;
            sens2_reg      <= sens2_next;
        end
        if (!hold3 && v2_reg)
        begin
            so_reg <= so_next;
        end
    end

    assign out_valid = v3_reg;
    assign so        = so_reg;

endmodule

[hw/rtl/bsc_pressure.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pressure
// Three stages: split D1 x SENS product, recombine and scale, subtract OFF
// and saturate.
// ----------------------------------------------------------------------------
module bsc_pressure
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  bsc_pkg::so_t                         so,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [bsc_pkg::TEMP_W-1:0]    temp_centideg,
    output logic signed [bsc_pkg::PRESS_W-1:0]   pressure_pa,
    output logic                                 cold_corrected
);

    localparam int OW   = bsc_pkg::OFF_W;
    localparam int HW   = bsc_pkg::CONV_W / 2;   // D1 half width
    localparam int PP_W = OW + HW + 1;           // partial product width
    localparam int PR_W = 64;
    localparam int Q_W  = PR_W - 21;
    localparam int DF_W = Q_W + 1;

    logic v1_reg, v2_reg, v3_reg;
    logic hold1, hold2, hold3;

    assign hold3    = v3_reg & out_stall;
    assign hold2    = v2_reg & hold3;
    assign hold1    = v1_reg & hold2;
    assign in_stall = hold1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (!hold1) v1_reg <= in_valid;
            if (!hold2) v2_reg <= v1_reg;
            if (!hold3) v3_reg <= v2_reg;
        end
    end

    // stage 1: two partial products on the D1 halves
    logic signed [PP_W-1:0] lo_next, hi_next, lo_reg, hi_reg;
    logic signed [bsc_pkg::TEMP_W-1:0] temp1_reg, temp2_reg, temp3_reg;
    logic cold1_reg, cold2_reg, cold3_reg;
    logic signed [OW-1:0] off1_reg, off2_reg;

    assign lo_next = so.sens * $signed({1'b0, so.d1[HW-1:0]});
    assign hi_next = so.sens * $signed({1'b0, so.d1[2*HW-1:HW]});

    // stage 2: recombine, divide by 2^21 toward zero
    logic signed [PR_W-1:0] prod, prod_adj, prod_q;
    logic signed [Q_W-1:0]  q_reg;

    assign prod     = (PR_W'(hi_reg) <<< HW) + PR_W'(lo_reg);
    assign prod_adj = prod + $signed({{(PR_W-21){1'b0}}, {21{prod[PR_W-1]}}});
    assign prod_q   = prod_adj >>> 21;

    // stage 3: subtract OFF, divide by 2^15 toward zero, clamp
    logic signed [DF_W-1:0] diff, diff_adj, p_full;
    logic signed [bsc_pkg::PRESS_W-1:0] p_next, p_reg;

    assign diff     = DF_W'(q_reg) - DF_W'(off2_reg);
    assign diff_adj = diff + $signed({{(DF_W-15){1'b0}}, {15{diff[DF_W-1]}}});
    assign p_full   = diff_adj >>> 15;

    always_comb
    begin
        if (p_full > DF_W'(64'sd2147483647))
            p_next = 32'sh7FFF_FFFF;
        else if (p_full < DF_W'(-64'sd2147483648))
            p_next = 32'sh8000_0000;
        else
            p_next = p_full[bsc_pkg::PRESS_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (!hold1 && in_valid)
        begin
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            temp1_reg <= so.temp_out;
            cold1_reg <= so.cold;
            off1_reg  <= so.off;
        end
        if (!hold2 && v1_reg)
        begin
            q_reg     <= prod_q[Q_W-1:0];
            temp2_reg <= temp1_reg;
            cold2_reg <= cold1_reg;
            off2_reg  <= off1_reg;
        end
        if (!hold3 && v2_reg)
        begin
            p_reg     <= p_next;
            temp3_reg <= temp2_reg;
            cold3_reg <= cold2_reg;
        end
    end

    assign out_valid      = v3_reg;
    assign temp_centideg  = temp3_reg;
    assign pressure_pa    = p_reg;
    assign cold_corrected = cold3_reg;

endmodule

[hw/rtl/baro_sensor_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order compensation of raw barometric temperature and pressure
// conversions into centidegrees and pascals.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  in       | sink      | in_valid / in_stall  | raw_temperature, raw_pressure
//  out      | source    | out_valid / out_stall| temp_centideg, pressure_pa,
//           |           |                      | cold_corrected
//  cfg      | sink      | cfg_we               | cfg_index, cfg_wdata
//
//  Nine register stages, one beat accepted per cycle while in_stall is low.
//  The multiplier stages (dT products, squares, split D1 x SENS product)
//  have a register after each.
//  Reset clears the valid bits and the calibration words only.
//  out_stall freezes the pipeline from the back; bubbles still close up.
// ----------------------------------------------------------------------------
module baro_sensor_compensation
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsc_pkg::IDX_W-1:0]           cfg_index,
    input  logic [bsc_pkg::WORD_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bsc_pkg::CONV_W-1:0]          raw_temperature,
    input  logic [bsc_pkg::CONV_W-1:0]          raw_pressure,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [bsc_pkg::TEMP_W-1:0]   temp_centideg,
    output logic signed [bsc_pkg::PRESS_W-1:0]  pressure_pa,
    output logic                                cold_corrected
);

    bsc_pkg::coef_t coef;
    bsc_pkg::fo_t   fo;
    bsc_pkg::so_t   so;
    logic           fo_valid, fo_stall;
    logic           so_valid, so_stall;

    bsc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .coef      (coef)
    );

    bsc_first_order u_first
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .coef      (coef),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .d2        (raw_temperature),
        .d1        (raw_pressure),
        .out_valid (fo_valid),
        .out_stall (fo_stall),
        .fo        (fo)
    );

    bsc_second_order u_second
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fo_valid),
        .in_stall  (fo_stall),
        .fo        (fo),
        .out_valid (so_valid),
        .out_stall (so_stall),
        .so        (so)
    );

    bsc_pressure u_press
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (so_valid),
        .in_stall       (so_stall),
        .so             (so),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .temp_centideg  (temp_centideg),
        .pressure_pa    (pressure_pa),
        .cold_corrected (cold_corrected)
    );

endmodule
